// ----- rtl/srt_pkg.sv -----
`timescale 1ns / 1ps

package srt_pkg;

	// Table geometry.
	localparam int ROUTES = 16;
	localparam int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam int CNT_W  = $clog2(ROUTES + 1);

	// Field widths.
	localparam int OP_W   = 2;
	localparam int NODE_W = 32;
	localparam int SVC_W  = 32;
	localparam int LINK_W = 8;
	localparam int DEC_W  = 2;
	localparam int CFG_W  = 32;
	localparam int CIDX_W = 2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [SVC_W-1:0]  svc_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [DEC_W-1:0]  dec_t;
	typedef logic [CFG_W-1:0]  cfg_data_t;
	typedef logic [CIDX_W-1:0] cfg_idx_t;

	// Operation codes.
	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_ADD    = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;

	// Decision codes.
	localparam dec_t DEC_LOCAL   = 2'd0;
	localparam dec_t DEC_FORWARD = 2'd1;
	localparam dec_t DEC_STORE   = 2'd2;

	// Configuration register indexes.
	localparam cfg_idx_t REG_LOCAL_NODE     = 2'd0;
	localparam cfg_idx_t REG_LOCAL_SERVICE  = 2'd1;
	localparam cfg_idx_t REG_DEFAULT_ENABLE = 2'd2;
	localparam cfg_idx_t REG_DEFAULT_LINK   = 2'd3;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/srt_req_if.sv -----
`timescale 1ns / 1ps

interface srt_req_if;
	logic          valid;
	logic          ready;
	srt_pkg::op_t   operation;
	srt_pkg::node_t node;
	srt_pkg::svc_t  service;
	srt_pkg::link_t link_id;

	modport source (output valid, output operation, output node, output service,
		output link_id, input ready);
	modport sink (input valid, input operation, input node, input service,
		input link_id, output ready);
endinterface

// ----- rtl/srt_rsp_if.sv -----
`timescale 1ns / 1ps

interface srt_rsp_if;
	logic          valid;
	logic          ready;
	srt_pkg::dec_t  decision;
	srt_pkg::link_t link_out;
	logic          success;

	modport source (output valid, output decision, output link_out, output success,
		input ready);
	modport sink (input valid, input decision, input link_out, input success,
		output ready);
endinterface

// ----- rtl/srt_ctrl.sv -----
`timescale 1ns / 1ps

module srt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  srt_pkg::sts_t  sts,
	output srt_pkg::cmd_t  cmd
);

	srt_pkg::state_t state_q;
	srt_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state: take a request, walk the table, let the last compare settle, commit.
	always_comb begin
		state_next = state_q;
		case (state_q)
			srt_pkg::ST_IDLE: begin
				if (req_valid) state_next = srt_pkg::ST_SCAN;
			end
			srt_pkg::ST_SCAN: begin
				if (sts.scan_last) state_next = srt_pkg::ST_DRAIN;
			end
			srt_pkg::ST_DRAIN: begin
				state_next = srt_pkg::ST_COMMIT;
			end
			srt_pkg::ST_COMMIT: begin
				if (sts.out_free) state_next = srt_pkg::ST_IDLE;
			end
			default: begin
				state_next = srt_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			srt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			srt_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
			end
			srt_pkg::ST_DRAIN: begin
				cmd.step = 1'b0;
			end
			srt_pkg::ST_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/srt_dpath.sv -----
`timescale 1ns / 1ps

module srt_dpath (
	input  logic                clk,
	input  logic                arst_n,
	srt_req_if.sink             req,
	srt_rsp_if.source           rsp,
	input  logic                cfg_we,
	input  srt_pkg::cfg_idx_t   cfg_index,
	input  srt_pkg::cfg_data_t  cfg_data,
	input  srt_pkg::cmd_t       cmd,
	output srt_pkg::sts_t       sts
);

	// Configuration registers.
	srt_pkg::node_t local_node_q;
	srt_pkg::svc_t  local_service_q;
	logic           default_enable_q;
	srt_pkg::link_t default_link_q;

	// Captured request.
	srt_pkg::op_t   op_q;
	srt_pkg::node_t node_q;
	srt_pkg::svc_t  service_q;
	srt_pkg::link_t link_q;

	// Route table storage and occupancy.
	srt_pkg::node_t mem_node [srt_pkg::ROUTES];
	srt_pkg::link_t mem_link [srt_pkg::ROUTES];
	logic [srt_pkg::ROUTES-1:0] valid_q;
	srt_pkg::cnt_t  count_q;

	// Scan pipeline.
	srt_pkg::idx_t  rd_idx_q;
	logic           pv_s1;
	srt_pkg::idx_t  idx_s1;
	srt_pkg::node_t rd_node_s1;
	srt_pkg::link_t rd_link_s1;

	// Scan results.
	logic           found_q;
	srt_pkg::idx_t  found_idx_q;
	srt_pkg::link_t found_link_q;
	logic           free_found_q;
	srt_pkg::idx_t  free_idx_q;

	// Result register.
	logic           out_valid_q;
	srt_pkg::dec_t  out_dec_q;
	srt_pkg::link_t out_link_q;
	logic           out_succ_q;

	logic           hit;
	logic           local_hit;
	logic           add_new;
	logic           wr_en;
	srt_pkg::idx_t  wr_idx;
	srt_pkg::dec_t  res_dec;
	srt_pkg::link_t res_link;
	logic           res_succ;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_node_q     <= '0;
			local_service_q  <= '0;
			default_enable_q <= 1'b0;
			default_link_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				srt_pkg::REG_LOCAL_NODE:     local_node_q     <= cfg_data;
				srt_pkg::REG_LOCAL_SERVICE:  local_service_q  <= cfg_data;
				srt_pkg::REG_DEFAULT_ENABLE: default_enable_q <= cfg_data[0];
				srt_pkg::REG_DEFAULT_LINK:   default_link_q   <= cfg_data[srt_pkg::LINK_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture at the input transfer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req.operation;
			node_q    <= req.node;
			service_q <= req.service;
			link_q    <= req.link_id;
		end
	end

	// Read address counter; one entry is read per scan cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			pv_s1    <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.step) begin
				rd_idx_q <= rd_idx_q + srt_pkg::idx_t'(1);
			end
			pv_s1 <= cmd.step;
		end
	end

	assign sts.scan_last = (rd_idx_q == srt_pkg::idx_t'(srt_pkg::ROUTES - 1));

	// Table memory: registered read on the scan port, one write at commit.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_node_s1 <= mem_node[rd_idx_q];
			rd_link_s1 <= mem_link[rd_idx_q];
			idx_s1     <= rd_idx_q;
		end
		if (wr_en) begin
			mem_node[wr_idx] <= node_q;
			mem_link[wr_idx] <= link_q;
		end
	end

	// Compare stage: keep the first matching entry and the lowest free slot.
	assign hit = pv_s1 && valid_q[idx_s1] && (rd_node_s1 == node_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (pv_s1) begin
			if (hit && !found_q) found_q <= 1'b1;
			if (!valid_q[idx_s1] && !free_found_q) free_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !found_q) begin
			found_idx_q  <= idx_s1;
			found_link_q <= rd_link_s1;
		end
		if (pv_s1 && !valid_q[idx_s1] && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// Result and table update for the captured request.
	assign local_hit = (node_q == local_node_q) &&
		((service_q == local_service_q) || (local_node_q != '0));
	assign add_new = !found_q && free_found_q &&
		(count_q != srt_pkg::cnt_t'(srt_pkg::ROUTES));
	assign wr_en  = cmd.commit && (op_q == srt_pkg::OP_ADD) && (found_q || add_new);
	assign wr_idx = found_q ? found_idx_q : free_idx_q;

	always_comb begin
		res_dec  = srt_pkg::DEC_LOCAL;
		res_link = '0;
		res_succ = 1'b0;
		case (op_q)
			srt_pkg::OP_LOOKUP: begin
				res_succ = 1'b1;
				if (local_hit) begin
					res_dec = srt_pkg::DEC_LOCAL;
				end else if (found_q) begin
					res_dec  = srt_pkg::DEC_FORWARD;
					res_link = found_link_q;
				end else if (default_enable_q) begin
					res_dec  = srt_pkg::DEC_FORWARD;
					res_link = default_link_q;
				end else begin
					res_dec = srt_pkg::DEC_STORE;
				end
			end
			srt_pkg::OP_ADD: begin
				res_succ = found_q || add_new;
			end
			srt_pkg::OP_REMOVE: begin
				res_succ = found_q;
			end
			default: begin
				res_succ = 1'b0;
			end
		endcase
	end

	// Valid bits and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			if ((op_q == srt_pkg::OP_ADD) && add_new) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q <= count_q + srt_pkg::cnt_t'(1);
			end else if ((op_q == srt_pkg::OP_REMOVE) && found_q) begin
				valid_q[found_idx_q] <= 1'b0;
				count_q <= count_q - srt_pkg::cnt_t'(1);
			end
		end
	end

	// Output register; frees when the result transfer completes.
	assign sts.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_dec_q  <= res_dec;
			out_link_q <= res_link;
			out_succ_q <= res_succ;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.decision = out_dec_q;
	assign rsp.link_out = out_link_q;
	assign rsp.success  = out_succ_q;

	// The count always matches the number of valid entries.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == srt_pkg::cnt_t'($countones(valid_q)))
		else $error("entry count differs from valid bits");

	// A new route never lands on an occupied slot.
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !found_q) |-> !valid_q[free_idx_q])
		else $error("add overwrites a valid entry");

	// A commit never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten");

	// A recorded match always points at a valid entry when committed.
	a_found_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && found_q) |-> valid_q[found_idx_q])
		else $error("match points at an invalid entry");

endmodule

// ----- rtl/static_route_table_unit.sv -----
`timescale 1ns / 1ps

// Channel      Role    Fields
// req          sink    operation, node, service, link_id
// rsp          source  decision, link_out, success
// cfg_*        write   cfg_we, cfg_index, cfg_data (no read-back)
//
// Each request passes the input transfer, a scan that reads one table entry per
// cycle on the single memory read port, a step for the last compare to settle
// and a commit step. The next request is taken once the commit is done.
// Reset clears the valid bits, the entry count and all configuration at once.
// A stalled result waits in the output register; a new request may be taken
// meanwhile, and its commit waits until the register is free.

module static_route_table_unit (
	input  logic               clk,
	input  logic               arst_n,
	srt_req_if.sink            req,
	srt_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  srt_pkg::cfg_idx_t  cfg_index,
	input  srt_pkg::cfg_data_t cfg_data
);

	srt_pkg::cmd_t cmd;
	srt_pkg::sts_t sts;

	// Sequencer.
	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table, compare and result path.
	srt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
